// File: hw/rtl/gbw_pkg.sv
package gbw_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 20;
  localparam int WGT_W   = 17;
  localparam int FRAC_W  = 16;

  // Mesh limits
  localparam int MAX_CELLS = 1024;
  localparam int COL_W     = $clog2(MAX_CELLS);

  // Derived datapath widths
  localparam int VX_W   = COL_W + COORD_W;
  localparam int AREA_W = 2 * COORD_W;
  localparam int SUM_W  = AREA_W + 2;
  localparam int REG_IDX_W = 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_DOWN   = 2'd3;

  // Corner order: top-left, top-right, bottom-right, bottom-left
  localparam int NUM_CORNERS = 4;
  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 1;
  localparam int CORNER_BR = 2;
  localparam int CORNER_BL = 3;

  // Clamp a raw cell count to 1..MAX_CELLS
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (n > CNT_W'(MAX_CELLS)) begin
      r = CNT_W'(MAX_CELLS);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/grid_bilinear_weight_unit.sv
// Channel  | Handshake                  | Payload
// point    | point_valid / point_stall  | point_x, point_y
// result   | result_valid / result_stall| cell_index, weight_top_left .. weight_bottom_left
// config   | write_enable               | write_index, write_data
//
// One word per cycle sustained unless a stalled result holds the pipeline;
// 1 + 16 + 5 + 17 = 39 register stages. The 16 cell-division
// stages and the 17 fraction-division stages set the depth, one quotient bit per stage.
// rst (synchronous) clears the stage valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; point_stall follows it.
module grid_bilinear_weight_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [gbw_pkg::REG_IDX_W-1:0]       write_index,
  input  logic [gbw_pkg::COORD_W-1:0]         write_data,
  input  logic                                point_valid,
  output logic                                point_stall,
  input  logic [gbw_pkg::COORD_W-1:0]         point_x,
  input  logic [gbw_pkg::COORD_W-1:0]         point_y,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [gbw_pkg::IDX_W-1:0]           cell_index,
  output logic [gbw_pkg::WGT_W-1:0]           weight_top_left,
  output logic [gbw_pkg::WGT_W-1:0]           weight_top_right,
  output logic [gbw_pkg::WGT_W-1:0]           weight_bottom_right,
  output logic [gbw_pkg::WGT_W-1:0]           weight_bottom_left
);

  localparam int CW = gbw_pkg::COORD_W;
  localparam int NW = gbw_pkg::CNT_W;
  localparam int LW = gbw_pkg::COL_W;
  localparam int VW = gbw_pkg::VX_W;
  localparam int AW = gbw_pkg::AREA_W;
  localparam int SW = gbw_pkg::SUM_W;
  localparam int IW = gbw_pkg::IDX_W;
  localparam int QW = gbw_pkg::WGT_W;
  localparam int FB = gbw_pkg::FRAC_W;
  localparam int NC = gbw_pkg::NUM_CORNERS;

  // Configuration registers
  logic [CW-1:0] cell_width, cell_height;
  logic [NW-1:0] cells_across, cells_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= CW'(640);
      cell_height  <= CW'(640);
      cells_across <= NW'(16);
      cells_down   <= NW'(16);
    end else if (write_enable) begin
      case (write_index)
        gbw_pkg::REG_CELL_WIDTH:   cell_width   <= write_data;
        gbw_pkg::REG_CELL_HEIGHT:  cell_height  <= write_data;
        gbw_pkg::REG_CELLS_ACROSS: cells_across <= write_data[NW-1:0];
        gbw_pkg::REG_CELLS_DOWN:   cells_down   <= write_data[NW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] na, nd;
  logic [LW-1:0] last_col, last_row;
  assign na = gbw_pkg::eff_count(cells_across);
  assign nd = gbw_pkg::eff_count(cells_down);
  assign last_col = LW'(na - NW'(1));
  assign last_row = LW'(nd - NW'(1));

  // Global advance: the whole pipeline holds while a result waits
  logic en;
  assign en = !(result_valid && result_stall);
  assign point_stall = !en;

  // Cell division stages: floor(x / cell_width), floor(y / cell_height)
  logic          dv_v  [0:CW];
  logic [CW-1:0] dv_x  [0:CW];
  logic [CW-1:0] dv_y  [0:CW];
  logic [CW-1:0] dv_rx [0:CW];
  logic [CW-1:0] dv_ry [0:CW];
  logic [CW-1:0] dv_qx [0:CW];
  logic [CW-1:0] dv_qy [0:CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_x[0]  <= point_x;
      dv_y[0]  <= point_y;
      dv_rx[0] <= '0;
      dv_ry[0] <= '0;
      dv_qx[0] <= '0;
      dv_qy[0] <= '0;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_div
    logic [CW:0] shx, shy;
    logic        gex, gey;
    assign shx = {dv_rx[k], dv_x[k][CW-1-k]};
    assign shy = {dv_ry[k], dv_y[k][CW-1-k]};
    assign gex = shx >= {1'b0, cell_width};
    assign gey = shy >= {1'b0, cell_height};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    // Retire one quotient bit per axis
    always_ff @(posedge clk) begin
      if (en) begin
        dv_x[k+1]  <= dv_x[k];
        dv_y[k+1]  <= dv_y[k];
        dv_rx[k+1] <= gex ? CW'(shx - {1'b0, cell_width}) : CW'(shx);
        dv_ry[k+1] <= gey ? CW'(shy - {1'b0, cell_height}) : CW'(shy);
        dv_qx[k+1] <= {dv_qx[k][CW-2:0], gex};
        dv_qy[k+1] <= {dv_qy[k][CW-2:0], gey};
      end
    end
  end

  // Clamp to the last column and row
  logic          c1_v;
  logic [CW-1:0] c1_x, c1_y;
  logic [LW-1:0] c1_col, c1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else if (en) begin
      c1_v <= dv_v[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_x   <= dv_x[CW];
      c1_y   <= dv_y[CW];
      c1_col <= (dv_qx[CW] > CW'(last_col)) ? last_col : LW'(dv_qx[CW]);
      c1_row <= (dv_qy[CW] > CW'(last_row)) ? last_row : LW'(dv_qy[CW]);
    end
  end

  // Corner positions and row offset
  logic          c2_v;
  logic [CW-1:0] c2_x, c2_y;
  logic [LW-1:0] c2_col;
  logic [VW-1:0] c2_vx0, c2_vy0;
  logic [IW-1:0] c2_rowoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v <= 1'b0;
    end else if (en) begin
      c2_v <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_x      <= c1_x;
      c2_y      <= c1_y;
      c2_col    <= c1_col;
      c2_vx0    <= VW'(c1_col) * VW'(cell_width);
      c2_vy0    <= VW'(c1_row) * VW'(cell_height);
      c2_rowoff <= IW'(c1_row) * IW'(na);
    end
  end

  // Distances to the near and far corner lines
  logic          c3_v;
  logic [CW-1:0] c3_dxl, c3_dxr, c3_dyt, c3_dyb;
  logic [IW-1:0] c3_idx;
  logic [VW:0]   vx1, vy1, xe, ye;

  assign vx1 = {1'b0, c2_vx0} + (VW+1)'(cell_width);
  assign vy1 = {1'b0, c2_vy0} + (VW+1)'(cell_height);
  assign xe  = (VW+1)'(c2_x);
  assign ye  = (VW+1)'(c2_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_v <= 1'b0;
    end else if (en) begin
      c3_v <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_dxl <= CW'(xe - {1'b0, c2_vx0});
      c3_dyt <= CW'(ye - {1'b0, c2_vy0});
      c3_dxr <= (xe >= vx1) ? CW'(xe - vx1) : CW'(vx1 - xe);
      c3_dyb <= (ye >= vy1) ? CW'(ye - vy1) : CW'(vy1 - ye);
      c3_idx <= c2_rowoff + IW'(c2_col);
    end
  end

  // Area to the opposite corner of each corner
  logic          c4_v;
  logic [AW-1:0] c4_area [0:NC-1];
  logic [IW-1:0] c4_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      c4_v <= 1'b0;
    end else if (en) begin
      c4_v <= c3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_area[gbw_pkg::CORNER_TL] <= AW'(c3_dxr) * AW'(c3_dyb);
      c4_area[gbw_pkg::CORNER_TR] <= AW'(c3_dxl) * AW'(c3_dyb);
      c4_area[gbw_pkg::CORNER_BR] <= AW'(c3_dxl) * AW'(c3_dyt);
      c4_area[gbw_pkg::CORNER_BL] <= AW'(c3_dxr) * AW'(c3_dyt);
      c4_idx <= c3_idx;
    end
  end

  // Area sum
  logic          c5_v;
  logic [AW-1:0] c5_area [0:NC-1];
  logic [SW-1:0] c5_sum;
  logic [IW-1:0] c5_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      c5_v <= 1'b0;
    end else if (en) begin
      c5_v <= c4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_area <= c4_area;
      c5_sum  <= SW'(c4_area[0]) + SW'(c4_area[1]) + SW'(c4_area[2]) + SW'(c4_area[3]);
      c5_idx  <= c4_idx;
    end
  end

  // Fraction division: integer bit first, then one fraction bit per stage
  logic          fr_v   [0:FB];
  logic [SW-1:0] fr_r   [0:FB][0:NC-1];
  logic [QW-1:0] fr_q   [0:FB][0:NC-1];
  logic [SW-1:0] fr_den [0:FB];
  logic          fr_z   [0:FB];
  logic [IW-1:0] fr_idx [0:FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_v[0] <= 1'b0;
    end else if (en) begin
      fr_v[0] <= c5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        if (SW'(c5_area[c]) >= c5_sum) begin
          fr_r[0][c] <= SW'(c5_area[c]) - c5_sum;
          fr_q[0][c] <= QW'(1);
        end else begin
          fr_r[0][c] <= SW'(c5_area[c]);
          fr_q[0][c] <= '0;
        end
      end
      fr_den[0] <= c5_sum;
      fr_z[0]   <= (c5_sum == '0);
      fr_idx[0] <= c5_idx;
    end
  end

  for (genvar k = 0; k < FB; k++) begin : g_frac
    always_ff @(posedge clk) begin
      if (rst) begin
        fr_v[k+1] <= 1'b0;
      end else if (en) begin
        fr_v[k+1] <= fr_v[k];
      end
    end

    for (genvar c = 0; c < NC; c++) begin : g_corner
      logic [SW:0] sh;
      logic        ge;
      assign sh = {fr_r[k][c], 1'b0};
      assign ge = sh >= {1'b0, fr_den[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          fr_r[k+1][c] <= ge ? SW'(sh - {1'b0, fr_den[k]}) : SW'(sh);
          fr_q[k+1][c] <= {fr_q[k][c][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fr_den[k+1] <= fr_den[k];
        fr_z[k+1]   <= fr_z[k];
        fr_idx[k+1] <= fr_idx[k];
      end
    end
  end

  // Drive the result word; a zero area sum gives zero weights
  assign result_valid        = fr_v[FB];
  assign cell_index          = fr_idx[FB];
  assign weight_top_left     = fr_z[FB] ? '0 : fr_q[FB][gbw_pkg::CORNER_TL];
  assign weight_top_right    = fr_z[FB] ? '0 : fr_q[FB][gbw_pkg::CORNER_TR];
  assign weight_bottom_right = fr_z[FB] ? '0 : fr_q[FB][gbw_pkg::CORNER_BR];
  assign weight_bottom_left  = fr_z[FB] ? '0 : fr_q[FB][gbw_pkg::CORNER_BL];

endmodule
